FILE: sv/ods_pkg.sv
package ods_pkg;

  // Field widths of requests and results.
  localparam int X_W        = 11;
  localparam int Y_W        = 10;
  localparam int R_W        = 11;
  localparam int KEY_W      = 21;
  localparam int RANK_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Default store capacity and depth of the queue between front and back.
  localparam int MAX_OBSTACLES_DEF = 32;
  localparam int Q_DEPTH           = 8;

  // Largest key; larger squared distances saturate here.
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

  // One stored obstacle.
  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [R_W-1:0]   radius;
    logic [KEY_W-1:0] key;
  } entry_t;

  // A classified request as it travels through the queue.
  typedef struct packed {
    entry_t entry;
    logic   keep;
    logic   eos;
  } item_t;

endpackage

FILE: sv/ods_front.sv
module ods_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ods_pkg::X_W-1:0]         in_obstacle_x,
  input  logic [ods_pkg::Y_W-1:0]         in_obstacle_y,
  input  logic [ods_pkg::R_W-1:0]         in_obstacle_radius,
  input  logic                            in_end_of_set,
  input  logic                            cfg_valid,
  input  logic [ods_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ods_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            credit_ret,
  output logic                            push,
  output ods_pkg::item_t                  push_data
);
  import ods_pkg::*;

  localparam int CRD_W = $clog2(Q_DEPTH + 1);
  localparam int SQX_W = 2 * X_W;
  localparam int SQY_W = 2 * Y_W;
  localparam int SUM_W = SQX_W + 1;

  logic [X_W-1:0]   start_x_r;
  logic [Y_W-1:0]   start_y_r;
  logic [CRD_W-1:0] credit_r;
  logic [CRD_W-1:0] credit_nxt;
  logic             accept;

  // Stage A: absolute differences.
  logic             a_valid_r;
  logic [X_W-1:0]   a_dx_r;
  logic [Y_W-1:0]   a_dy_r;
  item_t            a_item_r;

  // Stage B: squares.
  logic             b_valid_r;
  logic [SQX_W-1:0] b_sqx_r;
  logic [SQY_W-1:0] b_sqy_r;
  item_t            b_item_r;

  logic [SUM_W-1:0] sum;

  // Every accepted request holds one queue slot until the back pops it.
  assign accept = start && !busy;
  assign busy   = (credit_r == CRD_W'(Q_DEPTH));

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !credit_ret) begin
      credit_nxt = credit_r + CRD_W'(1);
    end else if (!accept && credit_ret) begin
      credit_nxt = credit_r - CRD_W'(1);
    end
  end

  // Configuration registers and pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      credit_r  <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_START_X: start_x_r <= cfg_data[X_W-1:0];
          CFG_START_Y: start_y_r <= cfg_data[Y_W-1:0];
          default:     ;
        endcase
      end
      credit_r  <= credit_nxt;
      a_valid_r <= accept;
      b_valid_r <= a_valid_r;
    end
  end

  // Pipeline payload: classify, take differences, then square.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_dx_r <= (start_x_r >= in_obstacle_x) ? start_x_r - in_obstacle_x
                                             : in_obstacle_x - start_x_r;
      a_dy_r <= (start_y_r >= in_obstacle_y) ? start_y_r - in_obstacle_y
                                             : in_obstacle_y - start_y_r;
      a_item_r.entry.x      <= in_obstacle_x;
      a_item_r.entry.y      <= in_obstacle_y;
      a_item_r.entry.radius <= in_obstacle_radius;
      a_item_r.entry.key    <= '0;
      a_item_r.keep         <= (in_obstacle_radius != '0);
      a_item_r.eos          <= in_end_of_set;
    end
    if (a_valid_r) begin
      b_sqx_r  <= SQX_W'(a_dx_r) * SQX_W'(a_dx_r);
      b_sqy_r  <= SQY_W'(a_dy_r) * SQY_W'(a_dy_r);
      b_item_r <= a_item_r;
    end
  end

  // Sum of squares, saturated to the key width.
  always_comb begin
    sum                 = SUM_W'(b_sqx_r) + SUM_W'(b_sqy_r);
    push_data           = b_item_r;
    push_data.entry.key = (sum > SUM_W'(KEY_MAX)) ? KEY_MAX : sum[KEY_W-1:0];
  end

  assign push = b_valid_r;

endmodule

FILE: sv/ods_fifo.sv
module ods_fifo #(
  parameter int DEPTH = ods_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ods_pkg::item_t push_data,
  input  logic           pop,
  output ods_pkg::item_t pop_data,
  output logic           empty
);
  import ods_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // The front's credit scheme must keep the queue from overrunning.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == CNT_W'(DEPTH)))
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

FILE: sv/ods_back.sv
module ods_back #(
  parameter int MAX_OBSTACLES = ods_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  ods_pkg::item_t               q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  output logic [ods_pkg::RANK_W-1:0]   out_rank,
  output logic [ods_pkg::X_W-1:0]      out_x,
  output logic [ods_pkg::Y_W-1:0]      out_y,
  output logic [ods_pkg::R_W-1:0]      out_radius,
  output logic [ods_pkg::KEY_W-1:0]    out_distance_sq,
  output logic                         out_entry_valid,
  output logic                         out_any_obstacle,
  output logic                         out_overflowed,
  output logic                         out_last_result
);
  import ods_pkg::*;

  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rank_r;
  logic             ovf_r;

  logic             out_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  entry_t           out_entry_r;
  logic             out_entry_valid_r;
  logic             out_any_r;
  logic             out_ovf_r;
  logic             out_last_r;

  entry_t           cells_r [MAX_OBSTACLES];
  logic [MAX_OBSTACLES-1:0] gt;
  logic             do_insert;
  logic             do_drop;
  logic             drain_last;

  // A request is taken from the queue only while loading.
  assign q_pop     = (state_r == ST_LOAD) && !q_empty;
  assign do_insert = q_pop && q_data.keep && (count_r < CNT_W'(MAX_OBSTACLES));
  assign do_drop   = q_pop && q_data.keep && (count_r == CNT_W'(MAX_OBSTACLES));
  assign drain_last = ((rank_r + CNT_W'(1)) == count_r);

  // Insertion cells: each occupied cell compares its key with the new one.
  // Cells with a larger key move up one place; ties stay ahead of the new entry.
  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    entry_t src;

    assign gt[i] = (CNT_W'(i) < count_r) && (cells_r[i].key > q_data.entry.key);

    if (i == 0) begin : g_first
      assign src = q_data.entry;
    end else begin : g_rest
      assign src = gt[i-1] ? cells_r[i-1] : q_data.entry;
    end

    always_ff @(posedge clk) begin
      if (state_r == ST_DRAIN) begin
        if (i < MAX_OBSTACLES - 1) begin
          cells_r[i] <= cells_r[(i < MAX_OBSTACLES - 1) ? i + 1 : i];
        end
      end else if (do_insert && (gt[i] || CNT_W'(i) == count_r)) begin
        cells_r[i] <= src;
      end
    end
  end

  // Sequencer: load requests, then drain the sorted run from the bottom cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_LOAD;
      count_r           <= '0;
      rank_r            <= '0;
      ovf_r             <= 1'b0;
      out_valid_r       <= 1'b0;
      out_rank_r        <= '0;
      out_entry_r       <= '0;
      out_entry_valid_r <= 1'b0;
      out_any_r         <= 1'b0;
      out_ovf_r         <= 1'b0;
      out_last_r        <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (do_insert) begin
            count_r <= count_r + CNT_W'(1);
          end
          if (do_drop) begin
            ovf_r <= 1'b1;
          end
          if (q_pop && q_data.eos) begin
            state_r <= ST_DRAIN;
            rank_r  <= '0;
          end
        end
        ST_DRAIN: begin
          out_valid_r <= 1'b1;
          out_ovf_r   <= ovf_r;
          if (count_r == '0) begin
            // Empty set: one result that carries no obstacle.
            out_rank_r        <= '0;
            out_entry_r       <= '0;
            out_entry_valid_r <= 1'b0;
            out_any_r         <= 1'b0;
            out_last_r        <= 1'b1;
            ovf_r             <= 1'b0;
            state_r           <= ST_LOAD;
          end else begin
            out_rank_r        <= RANK_W'(rank_r);
            out_entry_r       <= cells_r[0];
            out_entry_valid_r <= 1'b1;
            out_any_r         <= 1'b1;
            out_last_r        <= drain_last;
            rank_r            <= rank_r + CNT_W'(1);
            if (drain_last) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_x            = out_entry_r.x;
  assign out_y            = out_entry_r.y;
  assign out_radius       = out_entry_r.radius;
  assign out_distance_sq  = out_entry_r.key;
  assign out_entry_valid  = out_entry_valid_r;
  assign out_any_obstacle = out_any_r;
  assign out_overflowed   = out_ovf_r;
  assign out_last_result  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_OBSTACLES))
    else $error("entry count beyond capacity");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (count_r == '0 && !ovf_r && state_r == ST_LOAD))
    else $error("set state not cleared after the final result");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_entry_valid_r) |-> (out_last_r && out_rank_r == '0))
    else $error("empty result not alone in its run");

endmodule

FILE: sv/obstacle_distance_sorter.sv
// Sorts circular obstacles by squared distance from a configured start point.
// Requests are taken one per cycle while busy is low; a request with radius zero
// is not stored, and obstacles beyond MAX_OBSTACLES are dropped and reported
// through out_overflowed. The request with in_end_of_set high closes the set:
// once it has passed the front's difference and square stages and the queue,
// the results follow on consecutive cycles, nearest first, one per stored
// obstacle (a single result with out_entry_valid low for an empty set), the last
// one marked by out_last_result. The insertion cell chain shifts the sorted run
// out one entry a cycle; meanwhile up to eight further requests are queued
// before busy rises. Each result is held on the out_ ports for exactly one cycle
// with out_valid high and cannot be stalled, so the receiver must take it then.
// Write cfg_ registers only while no set is loading or draining.
module obstacle_distance_sorter #(
  parameter int MAX_OBSTACLES = ods_pkg::MAX_OBSTACLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ods_pkg::X_W-1:0]         in_obstacle_x,
  input  logic [ods_pkg::Y_W-1:0]         in_obstacle_y,
  input  logic [ods_pkg::R_W-1:0]         in_obstacle_radius,
  input  logic                            in_end_of_set,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ods_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ods_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  output logic [ods_pkg::RANK_W-1:0]      out_rank,
  output logic [ods_pkg::X_W-1:0]         out_x,
  output logic [ods_pkg::Y_W-1:0]         out_y,
  output logic [ods_pkg::R_W-1:0]         out_radius,
  output logic [ods_pkg::KEY_W-1:0]       out_distance_sq,
  output logic                            out_entry_valid,
  output logic                            out_any_obstacle,
  output logic                            out_overflowed,
  output logic                            out_last_result
);
  import ods_pkg::*;

  logic  push;
  item_t push_data;
  logic  pop;
  item_t pop_data;
  logic  q_empty;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  ods_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_obstacle_x      (in_obstacle_x),
    .in_obstacle_y      (in_obstacle_y),
    .in_obstacle_radius (in_obstacle_radius),
    .in_end_of_set      (in_end_of_set),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .credit_ret         (pop),
    .push               (push),
    .push_data          (push_data)
  );

  ods_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  ods_back #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_rank         (out_rank),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_radius       (out_radius),
    .out_distance_sq  (out_distance_sq),
    .out_entry_valid  (out_entry_valid),
    .out_any_obstacle (out_any_obstacle),
    .out_overflowed   (out_overflowed),
    .out_last_result  (out_last_result)
  );

endmodule
